FILE: src/kli_pkg.sv
// ----------------------------------------------------------------------------
// kli_pkg: shared types and constants for the keyframe linear interpolator
// Holds the beat types of the item and result channels, the function codes,
// the register map and the default sizes of the keyframe store.
// ----------------------------------------------------------------------------
package kli_pkg;

  // Default sizes of the keyframe store.
  localparam int KEYFRAMES_DEF = 8;
  localparam int LANES_DEF     = 4;

  // Configuration port geometry and register map.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [1:0] REG_STEPS       = 2'd1;
  localparam logic [1:0] REG_LOOP        = 2'd2;

  // Register reset values.
  localparam logic [3:0]  FRAME_COUNT_RST = 4'd5;
  localparam logic [15:0] STEPS_RST       = 16'd300;
  localparam logic        LOOP_RST        = 1'b0;

  // Fixed-point saturation limits.
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_PLAY    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

  // One input beat.
  typedef struct packed {
    func_t              func;
    logic [2:0]         frame_index;
    logic [1:0]         channel_index;
    logic signed [31:0] lane_data;
    logic               play_flag;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic signed [31:0] lane_value;
    logic               playing;
    logic [2:0]         segment;
    logic [15:0]        step;
  } result_t;

endpackage

FILE: src/kli_ram.sv
// ----------------------------------------------------------------------------
// kli_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/keyframe_linear_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator: linear keyframe animation of LANES Q16.16 lanes
// Write and play items and ticks that add nothing pass through the report and
// output steps to the result beat; a tick that adds the deltas first reads and
// writes back each lane; a restart or segment change fetches both keyframes of
// each lane, divides (one-bit-per-cycle divider, 32 steps) and writes back.
// Throughput: one item at a time; the next is taken the cycle after the result
// is queued.
// Reset: synchronous; a clearing pass over every table address (32 addresses at
// the default sizes) zeroes both memories, during which no item is accepted.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator #(
  parameter int KEYFRAMES = kli_pkg::KEYFRAMES_DEF,
  parameter int LANES     = kli_pkg::LANES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Item channel
  input  logic                         item_valid,
  output logic                         item_stall,
  input  kli_pkg::item_t               item,
  // Result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output kli_pkg::result_t             result,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kli_pkg::PADDR_W-1:0]  paddr,
  input  logic [kli_pkg::PDATA_W-1:0]  pwdata,
  output logic [kli_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  import kli_pkg::*;

  // Widths derived from the store sizes.
  localparam int KF_W  = $clog2(KEYFRAMES);
  localparam int LN_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int TA_W  = KF_W + LN_W;
  localparam int TA_D  = 1 << TA_W;
  localparam int LB_D  = 1 << LN_W;
  localparam int NW    = ((KF_W > 4) ? KF_W : 4) + 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE,
    S_ARD, S_AWR,
    S_DRD, S_DRD2, S_DDIFF, S_DSTART, S_DIV, S_DWR,
    S_REP, S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [3:0]  cfg_frame_count;
  logic [15:0] cfg_steps;
  logic        cfg_loop;

  // Control state
  logic [KF_W-1:0] seg;
  logic [15:0]     step_cnt;
  logic            play;
  logic            reload;
  logic [LN_W-1:0] k;
  logic [TA_W-1:0] sweep;
  item_t           item_r;

  // Datapath registers
  logic [31:0]     ka;
  logic [31:0]     cur_old;
  logic [32:0]     diff;
  logic [31:0]     div_quo;
  logic [15:0]     div_rem;
  logic            div_neg;
  logic [4:0]      div_cnt;

  // Memory ports
  logic            a_we;
  logic [TA_W-1:0] a_waddr;
  logic [31:0]     a_wdata;
  logic [TA_W-1:0] a_raddr;
  logic [31:0]     a_rdata;
  logic            b_we;
  logic [LN_W-1:0] b_waddr;
  logic [63:0]     b_wdata;
  logic [LN_W-1:0] b_raddr;
  logic [63:0]     b_rdata;

  // Keyframe table: address is {frame, lane}.
  kli_ram #(.WIDTH(32), .DEPTH(TA_D)) u_table (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // Lane state: {current value, delta} per lane.
  kli_ram #(.WIDTH(64), .DEPTH(LB_D)) u_lanes (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Configuration port decode.
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_COUNT: prdata = PDATA_W'(cfg_frame_count);
      REG_STEPS:       prdata = PDATA_W'(cfg_steps);
      REG_LOOP:        prdata = PDATA_W'(cfg_loop);
      default:         prdata = '0;
    endcase
  end

  // Item acceptance and field decode.
  logic            item_acc;
  logic [KF_W-1:0] frame_sel;
  logic [LN_W-1:0] in_lane_sel;
  logic [LN_W-1:0] lane_sel;
  logic            in_write_ok;
  logic            lane_ok;

  assign item_stall  = (state != S_IDLE);
  assign item_acc    = item_valid && !item_stall;
  assign frame_sel   = KF_W'(item.frame_index);
  assign in_lane_sel = LN_W'(item.channel_index);
  assign in_write_ok = (32'(item.frame_index) < KEYFRAMES) &&
                       (32'(item.channel_index) < LANES);
  assign lane_sel    = LN_W'(item_r.channel_index);
  assign lane_ok     = 32'(item_r.channel_index) < LANES;

  // Frames in use, clamped to the range 2 to KEYFRAMES.
  logic [NW-1:0] frames_used;
  logic          seg_more;
  logic          seg_end;
  logic [15:0]   divisor;

  always_comb begin
    if (NW'(cfg_frame_count) < NW'(2)) begin
      frames_used = NW'(2);
    end else if (NW'(cfg_frame_count) > NW'(KEYFRAMES)) begin
      frames_used = NW'(KEYFRAMES);
    end else begin
      frames_used = NW'(cfg_frame_count);
    end
  end

  assign seg_more = (NW'(seg) + NW'(2)) < frames_used;
  assign seg_end  = step_cnt >= cfg_steps;
  assign divisor  = (cfg_steps == 16'd0) ? 16'd1 : cfg_steps;

  // Saturating accumulate of one lane.
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;

  assign acc_sum = {b_rdata[63], b_rdata[63:32]} + {b_rdata[31], b_rdata[31:0]};
  always_comb begin
    if (acc_sum[32] != acc_sum[31]) begin
      acc_sat = acc_sum[32] ? Q_MIN : Q_MAX;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  // One restoring division step.
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [16:0] rem_sub;

  assign rem_sh  = {div_rem, div_quo[31]};
  assign rem_ge  = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  // Magnitude of the keyframe difference, and the signed, clamped delta.
  logic [32:0] diff_neg;
  logic [31:0] diff_mag;
  logic [31:0] delta_sat;

  assign diff_neg = -diff;
  assign diff_mag = diff[32] ? diff_neg[31:0] : diff[31:0];

  always_comb begin
    if (div_neg) begin
      delta_sat = (div_quo > Q_MIN) ? Q_MIN : (32'd0 - div_quo);
    end else begin
      delta_sat = div_quo[31] ? Q_MAX : div_quo;
    end
  end

  // Memory port steering.
  always_comb begin
    a_we    = 1'b0;
    a_waddr = {frame_sel, in_lane_sel};
    a_wdata = item.lane_data;
    b_we    = 1'b0;
    b_waddr = k;
    b_wdata = {acc_sat, b_rdata[31:0]};
    a_raddr = {seg, k};
    b_raddr = k;
    unique case (state)
      S_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = sweep;
        a_wdata = '0;
        b_we    = 32'(sweep) < LANES;
        b_waddr = sweep[LN_W-1:0];
        b_wdata = '0;
      end
      S_IDLE: begin
        a_we = item_acc && (item.func == FUNC_WRITE) && in_write_ok;
      end
      S_AWR: begin
        b_we = 1'b1;
      end
      S_DRD2: begin
        a_raddr = {seg + KF_W'(1), k};
      end
      S_DWR: begin
        b_we    = 1'b1;
        b_wdata = {(reload ? ka : cur_old), delta_sat};
      end
      S_REP, S_OUT: begin
        b_raddr = lane_sel;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, control state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      sweep           <= '0;
      cfg_frame_count <= FRAME_COUNT_RST;
      cfg_steps       <= STEPS_RST;
      cfg_loop        <= LOOP_RST;
      seg             <= '0;
      step_cnt        <= '0;
      play            <= 1'b0;
      reload          <= 1'b0;
      k               <= '0;
      div_cnt         <= '0;
      result_valid    <= 1'b0;
    end else begin
      // Register writes.
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_FRAME_COUNT: cfg_frame_count <= pwdata[3:0];
          REG_STEPS:       cfg_steps       <= pwdata[15:0];
          REG_LOOP:        cfg_loop        <= pwdata[0];
          default: begin
          end
        endcase
      end

      // Result beat leaves, unless the output step queues the next one.
      if (state != S_OUT && result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + TA_W'(1);
          if (sweep == TA_W'(TA_D - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (item_acc) begin
            item_r <= item;
            k      <= '0;
            unique case (item.func)
              FUNC_TICK: begin
                if (!play) begin
                  state <= S_REP;
                end else if (!seg_end) begin
                  step_cnt <= step_cnt + 16'd1;
                  state    <= S_ARD;
                end else if (seg_more) begin
                  step_cnt <= '0;
                  seg      <= seg + KF_W'(1);
                  reload   <= 1'b0;
                  state    <= S_DRD;
                end else if (cfg_loop) begin
                  step_cnt <= '0;
                  seg      <= '0;
                  reload   <= 1'b1;
                  state    <= S_DRD;
                end else begin
                  play  <= 1'b0;
                  state <= S_REP;
                end
              end
              FUNC_PLAY: begin
                play  <= item.play_flag;
                state <= S_REP;
              end
              FUNC_RESTART: begin
                step_cnt <= '0;
                seg      <= '0;
                reload   <= 1'b1;
                state    <= S_DRD;
              end
              default: begin
                state <= S_REP;
              end
            endcase
          end
        end

        // Accumulate: read a lane, then write back current plus delta.
        S_ARD: begin
          state <= S_AWR;
        end
        S_AWR: begin
          if (k == LN_W'(LANES - 1)) begin
            state <= S_REP;
          end else begin
            k     <= k + LN_W'(1);
            state <= S_ARD;
          end
        end

        // Delta: fetch both keyframes of the lane, divide, write back.
        S_DRD: begin
          state <= S_DRD2;
        end
        S_DRD2: begin
          ka      <= a_rdata;
          cur_old <= b_rdata[63:32];
          state   <= S_DDIFF;
        end
        S_DDIFF: begin
          diff  <= {a_rdata[31], a_rdata} - {ka[31], ka};
          state <= S_DSTART;
        end
        S_DSTART: begin
          div_quo <= diff_mag;
          div_neg <= diff[32];
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_quo <= {div_quo[30:0], rem_ge};
          div_rem <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          if (k == LN_W'(LANES - 1)) begin
            state <= S_REP;
          end else begin
            k     <= k + LN_W'(1);
            state <= S_DRD;
          end
        end

        // Report the named lane once the result register is free.
        S_REP: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded when the beat is queued.
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!result_valid || !result_stall)) begin
      result.lane_value <= lane_ok ? b_rdata[63:32] : '0;
      result.playing    <= play;
      result.segment    <= 3'(seg);
      result.step       <= step_cnt;
    end
  end

  // The divider remainder always stays below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rem < divisor))
    else $error("divider remainder not below divisor");

  // A segment start never reaches the last keyframe.
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    seg <= KF_W'(KEYFRAMES - 2))
    else $error("segment index beyond the last segment start");

  // The lane counter stays within the lanes in use.
  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    32'(k) < LANES)
    else $error("lane counter out of range");

  // A new result beat is only raised from the output step.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");

  // The division runs exactly 32 steps before the write-back.
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DWR) |-> ($past(state == S_DIV) && $past(div_cnt) == 5'd31))
    else $error("delta written back before the division finished");

endmodule
